FILE: hw/rtl/lobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and codes
// Event and outcome codes and the controller/datapath command and status
// structures of the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int QTY_W   = 31;
  localparam int ID_W    = 32;
  localparam int STAMP_W = 40;

  localparam logic [1:0] EV_DONE    = 2'd0;
  localparam logic [1:0] EV_UPDATE  = 2'd1;
  localparam logic [1:0] EV_SUMMARY = 2'd2;

  localparam logic [1:0] OC_RESTED = 2'd0;
  localparam logic [1:0] OC_FILLED = 2'd1;
  localparam logic [1:0] OC_ZERO   = 2'd2;
  localparam logic [1:0] OC_FULL   = 2'd3;

  typedef struct packed {
    logic load;       // capture the incoming order
    logic scan_start; // clear the best-so-far
    logic scan_step;  // examine the entry at the scan index
    logic fill;       // apply a fill to the best entry
    logic rest;       // write the remainder into a free slot
  } lobm_cmd_t;

  typedef struct packed {
    logic qty_zero;   // remaining quantity is zero
    logic scan_last;  // scan index is at the final entry
    logic found;      // a crossing entry was found
    logic free_found; // a free slot exists on the own side
  } lobm_sts_t;

endpackage

FILE: hw/rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority matching engine
// Matches limit orders against a bounded two-sided book.
// ----------------------------------------------------------------------------
// Usage:
//   One order beat enters on the in_ channel; it is taken when in_valid is
//   high and in_stall is low. The block then emits one out_ beat per resting
//   order touched (completed or updated) and a closing summary beat with
//   out_last_result set.
//   Each fill costs a full scan of the opposite side, one entry per cycle.
//   An order that leaves a remainder ends with one more scan that finds no
//   crossing entry; a fully filled one goes straight to its summary, and a
//   zero-quantity one never scans. The single sequencer holds in_stall high
//   until the order ends.
//   Reset empties both sides and clears the arrival stamp; it needs no
//   clearing pass. When out_stall is high the current beat holds and the
//   sequencer waits before it issues another beat.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int SIDE_DEPTH = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_order_side,
  input  logic [31:0] in_order_price,
  input  logic [30:0] in_order_quantity,
  input  logic [31:0] in_order_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_event_order_id,
  output logic [1:0]  out_outcome,
  output logic        out_last_result
);
  import lobm_pkg::*;

  lobm_cmd_t   cmd;
  lobm_sts_t   sts;
  logic [31:0] ev_id, ord_id;
  logic        ev_done;

  lobm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_order_quantity,
    .out_valid, .out_stall, .out_event_kind, .out_event_order_id,
    .out_outcome, .out_last_result, .cmd, .sts, .ev_id, .ev_done, .ord_id
  );

  lobm_datapath #(.SIDE_DEPTH(SIDE_DEPTH), .PRICE_BITS(PRICE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_order_side, .in_order_price,
    .in_order_quantity, .in_order_id, .ev_id, .ev_done, .ord_id
  );

endmodule

FILE: hw/rtl/lobm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_datapath: book storage and match datapath
// Holds both side tables, scans one entry per cycle for the best crossing
// order, applies fills and rests remainders.
// ----------------------------------------------------------------------------
module lobm_datapath #(
  parameter int SIDE_DEPTH = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lobm_pkg::lobm_cmd_t       cmd,
  output lobm_pkg::lobm_sts_t       sts,
  input  logic                      in_order_side,
  input  logic [31:0]               in_order_price,
  input  logic [30:0]               in_order_quantity,
  input  logic [31:0]               in_order_id,
  output logic [31:0]               ev_id,
  output logic                      ev_done,
  output logic [31:0]               ord_id
);
  import lobm_pkg::*;

  localparam int IW = $clog2(SIDE_DEPTH);

  logic [1:0]            vld_r [SIDE_DEPTH];   // [1] buy, [0] sell
  logic [PRICE_BITS-1:0] prc_r [2][SIDE_DEPTH];
  logic [QTY_W-1:0]      rem_r [2][SIDE_DEPTH];
  logic [ID_W-1:0]       idn_r [2][SIDE_DEPTH];
  logic [STAMP_W-1:0]    arr_r [2][SIDE_DEPTH];
  logic [STAMP_W-1:0]    stamp_r;

  logic                  side_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_W-1:0]      qty_r;
  logic [ID_W-1:0]       id_r;
  logic [IW-1:0]         idx_r;
  logic                  found_r;
  logic [IW-1:0]         best_r;
  logic [PRICE_BITS-1:0] bprc_r;
  logic [STAMP_W-1:0]    barr_r;

  logic                  opp, ov, crosses, better;
  logic [PRICE_BITS-1:0] eprc;
  logic [STAMP_W-1:0]    earr;
  logic [QTY_W-1:0]      brem, fill_q;
  logic                  free_any;
  logic [IW-1:0]         free_idx;

  always_comb begin
    opp     = ~side_r;
    ov      = vld_r[idx_r][opp];
    eprc    = prc_r[opp][idx_r];
    earr    = arr_r[opp][idx_r];
    crosses = side_r ? (eprc <= price_r) : (eprc >= price_r);
    better  = !found_r || (side_r ? (eprc < bprc_r) : (eprc > bprc_r)) ||
              (eprc == bprc_r && earr < barr_r);
    brem    = rem_r[opp][best_r];
    fill_q  = (qty_r < brem) ? qty_r : brem;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SIDE_DEPTH - 1; i >= 0; i--) begin
      if (!vld_r[i][side_r]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_DEPTH; i++) vld_r[i] <= 2'b00;
      stamp_r <= '0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.load) begin
        side_r  <= in_order_side;
        price_r <= PRICE_BITS'(in_order_price);
        qty_r   <= in_order_quantity;
        id_r    <= in_order_id;
      end
      if (cmd.scan_start) begin
        found_r <= 1'b0;
        idx_r   <= '0;
      end
      if (cmd.scan_step) begin
        if (ov && crosses && better) begin
          found_r <= 1'b1;
          best_r  <= idx_r;
          bprc_r  <= eprc;
          barr_r  <= earr;
        end
        idx_r <= (idx_r == IW'(SIDE_DEPTH - 1)) ? '0 : idx_r + IW'(1);
      end
      if (cmd.fill) begin
        qty_r <= qty_r - fill_q;
        rem_r[opp][best_r] <= brem - fill_q;
        if (brem == fill_q) vld_r[best_r][opp] <= 1'b0;
        ev_id   <= idn_r[opp][best_r];
        ev_done <= (brem == fill_q);
      end
      if (cmd.rest) begin
        vld_r[free_idx][side_r]   <= 1'b1;
        prc_r[side_r][free_idx]   <= price_r;
        rem_r[side_r][free_idx]   <= qty_r;
        idn_r[side_r][free_idx]   <= id_r;
        arr_r[side_r][free_idx]   <= stamp_r;
        stamp_r <= stamp_r + STAMP_W'(1);
      end
    end
  end

  assign ord_id         = id_r;
  assign sts.qty_zero   = (qty_r == '0);
  assign sts.scan_last  = (idx_r == IW'(SIDE_DEPTH - 1));
  assign sts.found      = found_r;
  assign sts.free_found = free_any;

`ifndef SYNTHESIS
  a_fill_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> found_r) else $error("fill without a crossing entry");
  a_fill_qty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> qty_r != '0) else $error("fill with nothing left");
  a_rest_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rest |-> free_any) else $error("rest without a free slot");
`endif

endmodule

FILE: hw/rtl/lobm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ctrl: match sequencer
// Steps each order through scan, fill, rest and summary, and drives the
// output register.
// ----------------------------------------------------------------------------
module lobm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [30:0]         in_order_quantity,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_event_kind,
  output logic [31:0]         out_event_order_id,
  output logic [1:0]          out_outcome,
  output logic                out_last_result,
  output lobm_pkg::lobm_cmd_t cmd,
  input  lobm_pkg::lobm_sts_t sts,
  input  logic [31:0]         ev_id,
  input  logic                ev_done,
  input  logic [31:0]         ord_id
);
  import lobm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_EVT  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic        ovld_r, ovld_nxt;
  logic [1:0]  kind_r, kind_nxt, outc_r, outc_nxt;
  logic [31:0] oid_r, oid_nxt;
  logic        last_r, last_nxt;
  logic        out_free;
  // A zero-quantity order never scans, so its summary is tagged on entry.
  logic        zero_r;

  assign out_free = !ovld_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r && out_stall;
    kind_nxt  = kind_r;
    outc_nxt  = outc_r;
    oid_nxt   = oid_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = (in_order_quantity == '0) ? S_END : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_FILL;
      end
      S_FILL: begin
        if (sts.found && !sts.qty_zero) begin
          cmd.fill = 1'b1;
          state_nxt = S_EVT;
        end else begin
          state_nxt = S_END;
        end
      end
      S_EVT: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          kind_nxt = ev_done ? EV_DONE : EV_UPDATE;
          oid_nxt  = ev_id;
          outc_nxt = OC_RESTED;
          last_nxt = 1'b0;
          cmd.scan_start = 1'b1;
          state_nxt = sts.qty_zero ? S_END : S_SCAN;
        end
      end
      S_END: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          kind_nxt = EV_SUMMARY;
          oid_nxt  = ord_id;
          last_nxt = 1'b1;
          state_nxt = S_WAIT;
          if (zero_r) begin
            outc_nxt = OC_ZERO;
          end else if (sts.qty_zero) begin
            outc_nxt = OC_FILLED;
          end else if (sts.free_found) begin
            outc_nxt = OC_RESTED;
            cmd.rest = 1'b1;
          end else begin
            outc_nxt = OC_FULL;
          end
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      if (state_r == S_IDLE && in_valid) zero_r <= (in_order_quantity == '0);
    end
    kind_r <= kind_nxt;
    oid_r  <= oid_nxt;
    last_r <= last_nxt;
    outc_r <= outc_nxt;
  end

  assign out_valid          = ovld_r;
  assign out_event_kind     = kind_r;
  assign out_event_order_id = oid_r;
  assign out_outcome        = outc_r;
  assign out_last_result    = last_r;

`ifndef SYNTHESIS
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != S_IDLE) else $error("accept lost");
  a_last_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> out_event_kind == EV_SUMMARY)
    else $error("last beat is not a summary");
  a_rest_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rest |=> state_r == S_WAIT) else $error("rest out of sequence");
`endif

endmodule

FILE: bench/limit_order_book_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_tb: self-checking bench for the order book matcher
// Walks a directed table of orders, then random order flow around a few price
// clusters, with random idling and stalls on both channels. Every result beat
// is compared against a behavioural book model kept in the bench.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;
  import lobm_pkg::*;

  localparam int DEPTH       = 32;
  localparam int N_RANDOM    = 326;
  localparam int WATCH_MAX   = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] oid;
    logic [1:0]  outc;
    logic        last;
  } evt_t;

  typedef struct {
    logic        side;
    logic [31:0] price;
    logic [30:0] qty;
    logic [31:0] id;
    logic        has_exp; // summary beat of the order typed in by hand
    logic [1:0]  exp_kind;
    logic [1:0]  exp_outc;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_order_side = 1'b0;
  logic [31:0] in_order_price = '0;
  logic [30:0] in_order_quantity = '0;
  logic [31:0] in_order_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [31:0] out_event_order_id;
  logic [1:0]  out_outcome;
  logic        out_last_result;

  // Book model: index 1 is the buy side, index 0 the sell side.
  logic        bk_valid [2][DEPTH];
  logic [31:0] bk_price [2][DEPTH];
  logic [30:0] bk_rem   [2][DEPTH];
  logic [31:0] bk_id    [2][DEPTH];
  logic [39:0] bk_stamp [2][DEPTH];
  logic [39:0] stamp_ctr;

  evt_t pending_events[$];
  evt_t hand_checks[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;     // no idling near the end
  bit   hold_req = 1'b0;  // asks the receiver for its long hold-off
  bit   held = 1'b0;      // the long hold-off has been done
  row_t dir_rows[$];

  always #10 clk = ~clk;

  limit_order_book_matcher #(.SIDE_DEPTH(DEPTH), .PRICE_BITS(32)) DUT (.*);

  function automatic evt_t mk_evt(logic [1:0] k, logic [31:0] id, logic [1:0] o, logic l);
    evt_t e;
    e.kind = k; e.oid = id; e.outc = o; e.last = l;
    return e;
  endfunction

  function automatic void expect_evt(evt_t e);
    pending_events.insert(pending_events.size(), e);
  endfunction

  // Matches one order against the model book and queues the expected beats.
  function automatic void match_order(logic side, logic [31:0] price, logic [30:0] qty_in,
                                      logic [31:0] id);
    int opp, best, slot;
    logic [30:0] qty, fill;
    bit crosses, better;
    opp = side ? 0 : 1;
    qty = qty_in;
    if (qty == 0) begin
      expect_evt(mk_evt(EV_SUMMARY, id, OC_ZERO, 1'b1));
      return;
    end
    for (int it = 0; it < DEPTH && qty != 0; it++) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[opp][i]) continue;
        crosses = side ? (bk_price[opp][i] <= price) : (bk_price[opp][i] >= price);
        if (!crosses) continue;
        if (best < 0) best = i;
        else begin
          better = side ? (bk_price[opp][i] < bk_price[opp][best])
                        : (bk_price[opp][i] > bk_price[opp][best]);
          if (better || (bk_price[opp][i] == bk_price[opp][best] &&
                         bk_stamp[opp][i] < bk_stamp[opp][best]))
            best = i;
        end
      end
      if (best < 0) break;
      fill = (qty < bk_rem[opp][best]) ? qty : bk_rem[opp][best];
      qty -= fill;
      bk_rem[opp][best] -= fill;
      if (bk_rem[opp][best] == 0) begin
        bk_valid[opp][best] = 1'b0;
        expect_evt(mk_evt(EV_DONE, bk_id[opp][best], OC_RESTED, 1'b0));
      end else begin
        expect_evt(mk_evt(EV_UPDATE, bk_id[opp][best], OC_RESTED, 1'b0));
      end
    end
    if (qty == 0) begin
      expect_evt(mk_evt(EV_SUMMARY, id, OC_FILLED, 1'b1));
      return;
    end
    slot = -1;
    for (int i = 0; i < DEPTH; i++)
      if (!bk_valid[side][i] && slot < 0) slot = i;
    if (slot < 0) begin
      expect_evt(mk_evt(EV_SUMMARY, id, OC_FULL, 1'b1));
      return;
    end
    bk_valid[side][slot] = 1'b1;
    bk_price[side][slot] = price;
    bk_rem[side][slot] = qty;
    bk_id[side][slot] = id;
    bk_stamp[side][slot] = stamp_ctr;
    stamp_ctr++;
    expect_evt(mk_evt(EV_SUMMARY, id, OC_RESTED, 1'b1));
  endfunction

  // Receiver: random stall bursts, plus one long hold-off counted here.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Checker and watchdog.
  always @(posedge clk) begin
    evt_t got, want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
        $display("%0t watchdog expired", $realtime);
        $display("status: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = mk_evt(out_event_kind, out_event_order_id, out_outcome, out_last_result);
        if (pending_events.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %p", $realtime, got);
          errors++;
        end else begin
          want = pending_events.pop_front();
          if (got.kind != want.kind || got.oid != want.oid || got.outc != want.outc ||
              got.last != want.last) begin
            $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
            errors++;
          end
          if (hand_checks.size() != 0 && want.last) begin
            // typed-in expectation for the summary of a directed row
            if (hand_checks[0].oid == want.oid && hand_checks[0].kind == got.kind) begin
              if (hand_checks[0].outc != got.outc) begin
                $display("%0t table mismatch: expected %p actual %p", $realtime,
                         hand_checks[0], got);
                errors++;
              end
              void'(hand_checks.pop_front());
            end
          end
        end
      end
    end
  end

  task automatic send_order(logic side, logic [31:0] price, logic [30:0] qty,
                            logic [31:0] id);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_order_side <= side;
    in_order_price <= price;
    in_order_quantity <= qty;
    in_order_id <= id;
    do @(posedge clk); while (in_stall);
    match_order(side, price, qty, id);
  endtask

  function automatic row_t mk_row(logic s, logic [31:0] p, logic [30:0] q, logic [31:0] id,
                                  logic he, logic [1:0] o);
    row_t r;
    r.side = s; r.price = p; r.qty = q; r.id = id;
    r.has_exp = he; r.exp_kind = EV_SUMMARY; r.exp_outc = o;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    logic        side;
    logic [31:0] price, base;
    logic [30:0] qty;
    logic [31:0] oid;
    int          mode;
    foreach (bk_valid[s, i]) bk_valid[s][i] = 1'b0;
    stamp_ctr = '0;

    // Directed table.
    add_row(mk_row(1, 32'd100, 31'd0, 32'h0000_0001, 1, OC_ZERO));
    add_row(mk_row(0, 32'd100, 31'd5, 32'hFFFF_FFFF, 1, OC_RESTED));
    add_row(mk_row(0, 32'd100, 31'd7, 32'h0000_0002, 1, OC_RESTED));
    add_row(mk_row(0, 32'd90,  31'd3, 32'h0000_0003, 1, OC_RESTED));
    add_row(mk_row(0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0004, 1, OC_RESTED));
    add_row(mk_row(1, 32'd0, 31'd9, 32'h0000_0005, 1, OC_RESTED));
    add_row(mk_row(1, 32'd100, 31'd10, 32'h0000_0006, 0, OC_FILLED));
    add_row(mk_row(1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0007, 0, OC_RESTED));
    add_row(mk_row(0, 32'd0, 31'd20, 32'h0000_0008, 0, OC_RESTED));
    add_row(mk_row(0, 32'd0, 31'd0, 32'hA5A5_5A5A, 1, OC_ZERO));
    // Fill the sell side up; its last rows and the row after it are rejected.
    for (int i = 0; i < DEPTH; i++)
      add_row(mk_row(0, 32'h8000_0000 + i, 31'd1, 32'h100 + i, 0, OC_RESTED));
    add_row(mk_row(0, 32'h8000_0000, 31'd1, 32'h0000_0200, 1, OC_FULL));
    // Sweep the whole side: 32 fills plus a summary.
    add_row(mk_row(1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0201, 0, OC_RESTED));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].has_exp)
        hand_checks.insert(hand_checks.size(),
                           mk_evt(dir_rows[k].exp_kind, dir_rows[k].id,
                                  dir_rows[k].exp_outc, 1'b1));
      send_order(dir_rows[k].side, dir_rows[k].price, dir_rows[k].qty, dir_rows[k].id);
    end

    // Sender pauses until all results are back.
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);

    // Random order flow around a drifting price cluster.
    base = 32'd1000;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 60) hold_req = 1'b1;
      if (n == N_RANDOM - 40) quiet = 1'b1;
      mode = $urandom_range(0, 19);
      side = 1'($urandom_range(0, 1));
      oid = $urandom;
      if (mode == 0) begin
        price = $urandom;
        qty = 31'($urandom);
      end else if (mode == 1) begin
        price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        qty = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
      end else begin
        price = base + 32'($urandom_range(0, 12)) - 32'd6;
        qty = 31'($urandom_range(1, 40));
      end
      if ($urandom_range(0, 30) == 0) base = 32'($urandom_range(100, 32'h7FFF_0000));
      send_order(side, price, qty, oid);
    end
    in_valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && hand_checks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_datapath.sv
hw/rtl/lobm_ctrl.sv
hw/rtl/limit_order_book_matcher.sv
bench/limit_order_book_matcher_tb.sv
